[design/ckfb_pkg.sv]
package ckfb_pkg;

    // Layer address width (wraps modulo 2^ADDR_BITS)
    localparam int ADDR_BITS = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_TEMPO    = 3'd6;

    // Action codes carried on the first pixel of a pass
    localparam logic [1:0] ACT_KEEP      = 2'd0;
    localparam logic [1:0] ACT_FADE_IN   = 2'd1;
    localparam logic [1:0] ACT_FADE_AWAY = 2'd2;
    localparam logic [1:0] ACT_STOP      = 2'd3;

    // Transparent marker and full fade level
    localparam logic [31:0] KEY_MARKER = 32'hFF66_6999;
    localparam logic [7:0]  FADE_MAX   = 8'd255;

    typedef enum logic [1:0] {
        FADE_STATIC = 2'd0,
        FADE_IN     = 2'd1,
        FADE_AWAY   = 2'd2
    } t_fade_mode;

    typedef struct packed {
        t_fade_mode mode;
        logic [7:0] level;
    } t_fade_state;

    typedef struct packed {
        logic [31:0] pixel_in;
        logic        begin_image;
        logic        key_capture;
        logic [1:0]  action;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_BITS-1:0] layer_address;
        logic [31:0]          pixel_out;
        logic                 in_window;
        logic                 keyed;
        logic                 end_of_image;
    } t_out_item;

endpackage

[design/ckfb_fade.sv]
// One fade step, applied on the first pixel of an image pass
module ckfb_fade (
    input  logic                i_step,
    input  ckfb_pkg::t_fade_state i_state,
    input  logic [7:0]          i_tempo,
    output ckfb_pkg::t_fade_state o_state
);

    logic [8:0] w_sum;

    assign w_sum = {1'b0, i_state.level} + {1'b0, i_tempo};

    always_comb begin
        o_state = i_state;
        if (i_step && i_state.mode == ckfb_pkg::FADE_IN && i_state.level != 8'd0) begin
            // fade in: level drops toward 0, mode goes static on arrival
            if (i_tempo >= i_state.level) begin
                o_state.level = 8'd0;
                o_state.mode  = ckfb_pkg::FADE_STATIC;
            end else begin
                o_state.level = i_state.level - i_tempo;
            end
        end else if (i_step && i_state.mode == ckfb_pkg::FADE_AWAY &&
                     i_state.level != ckfb_pkg::FADE_MAX) begin
            // fade out: level rises toward 255, saturating
            if (w_sum >= {1'b0, ckfb_pkg::FADE_MAX}) begin
                o_state.level = ckfb_pkg::FADE_MAX;
                o_state.mode  = ckfb_pkg::FADE_STATIC;
            end else begin
                o_state.level = w_sum[7:0];
            end
        end
    end

endmodule

[design/color_key_fade_blit_core.sv]
// Each accepted input transaction is registered into the output register as a valid result.
// Throughput: one pixel per cycle unless stalled; the output register stalls input when full
// and not drained, and input also stalls after each configuration write
// while the registered layer origin (window_width * pos_y + pos_x) updates.
// Reset (synchronous, active low): registers to defaults, fade level 0, static mode,
// no key, counters at the image origin, output empty.
module color_key_fade_blit_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ckfb_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ckfb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  ckfb_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ckfb_pkg::t_out_item               o_out_data
);

    localparam int AW    = ckfb_pkg::ADDR_BITS;
    localparam int SUM_W = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;

    // configuration registers
    logic [12:0] r_win_w, r_win_h, r_img_w, r_img_h;
    logic [11:0] r_pos_x, r_pos_y;
    logic [7:0]  r_tempo;
    logic [AW-1:0] r_origin;
    logic        r_cfg_hold;

    // pass state
    ckfb_pkg::t_fade_state   r_fade;
    logic [31:0]             r_key_color;
    logic                    r_key_valid;
    logic [COORD_BITS-1:0]   r_col, r_row;
    logic [AW-1:0]           r_row_base;

    // output register
    logic                r_out_valid;
    ckfb_pkg::t_out_item r_out_data;

    logic                    w_cfg_we, w_accept, w_begin, w_capture;
    logic [25:0]             w_origin_full;
    logic [COORD_BITS-1:0]   w_col, w_row;
    logic [AW-1:0]           w_base, w_addr;
    ckfb_pkg::t_fade_state   w_fade_sel, n_fade;
    logic [31:0]             n_key_color;
    logic                    n_key_valid;
    logic                    w_keyed, w_inside, w_row_end, w_img_end;
    logic [COORD_BITS-1:0]   n_col, n_row;
    logic [AW-1:0]           n_row_base;
    ckfb_pkg::t_out_item     n_out;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;
    assign o_in_ready  = (!r_out_valid || i_out_ready) && !r_cfg_hold;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_w    <= 13'd1024;
            r_win_h    <= 13'd768;
            r_img_w    <= 13'd1;
            r_img_h    <= 13'd1;
            r_pos_x    <= 12'd0;
            r_pos_y    <= 12'd0;
            r_tempo    <= 8'd1;
            r_cfg_hold <= 1'b0;
        end else begin
            r_cfg_hold <= w_cfg_we;
            if (w_cfg_we) begin
                case (i_cfg_index)
                    ckfb_pkg::REG_WINDOW_WIDTH:  r_win_w <= i_cfg_data[12:0];
                    ckfb_pkg::REG_WINDOW_HEIGHT: r_win_h <= i_cfg_data[12:0];
                    ckfb_pkg::REG_IMAGE_WIDTH:   r_img_w <= i_cfg_data[12:0];
                    ckfb_pkg::REG_IMAGE_HEIGHT:  r_img_h <= i_cfg_data[12:0];
                    ckfb_pkg::REG_POS_X:         r_pos_x <= i_cfg_data[11:0];
                    ckfb_pkg::REG_POS_Y:         r_pos_y <= i_cfg_data[11:0];
                    ckfb_pkg::REG_FADE_TEMPO:    r_tempo <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // layer origin, registered off the multiply
    assign w_origin_full = 26'(r_win_w) * 26'(r_pos_y) + 26'(r_pos_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
        end else begin
            r_origin <= AW'(w_origin_full);
        end
    end

    // first-pixel restart and fade mode select
    assign w_begin   = i_in_data.begin_image;
    assign w_capture = w_begin && i_in_data.key_capture;
    assign w_col     = w_begin ? '0 : r_col;
    assign w_row     = w_begin ? '0 : r_row;
    assign w_base    = w_begin ? r_origin : r_row_base;

    always_comb begin
        w_fade_sel = r_fade;
        if (w_begin) begin
            case (i_in_data.action)
                ckfb_pkg::ACT_KEEP:      w_fade_sel.mode = r_fade.mode;
                ckfb_pkg::ACT_FADE_IN:   w_fade_sel.mode = ckfb_pkg::FADE_IN;
                ckfb_pkg::ACT_FADE_AWAY: w_fade_sel.mode = ckfb_pkg::FADE_AWAY;
                ckfb_pkg::ACT_STOP:      w_fade_sel.mode = ckfb_pkg::FADE_STATIC;
                default:                 w_fade_sel.mode = r_fade.mode;
            endcase
        end
    end

    ckfb_fade u_fade (
        .i_step  (w_begin),
        .i_state (w_fade_sel),
        .i_tempo (r_tempo),
        .o_state (n_fade)
    );

    // color key
    assign n_key_color = w_capture ? i_in_data.pixel_in : r_key_color;
    assign n_key_valid = w_capture || r_key_valid;
    assign w_keyed     = (i_in_data.pixel_in == ckfb_pkg::KEY_MARKER) ||
                         (n_key_valid && i_in_data.pixel_in == n_key_color);

    // window check and pass position
    assign w_inside  = (SUM_W'(r_pos_x) + SUM_W'(w_col) < SUM_W'(r_win_w)) &&
                       (SUM_W'(r_pos_y) + SUM_W'(w_row) < SUM_W'(r_win_h));
    assign w_row_end = (SUM_W'(w_col) + SUM_W'(1) >= SUM_W'(r_img_w));
    assign w_img_end = w_row_end && (SUM_W'(w_row) + SUM_W'(1) >= SUM_W'(r_img_h));
    assign w_addr    = w_base + AW'(w_col);

    always_comb begin
        n_out.layer_address = w_addr;
        n_out.pixel_out     = w_keyed ? ckfb_pkg::KEY_MARKER
                                      : {n_fade.level, i_in_data.pixel_in[23:0]};
        n_out.in_window     = w_inside;
        n_out.keyed         = w_keyed;
        n_out.end_of_image  = w_img_end;
    end

    // counter advance
    always_comb begin
        if (w_img_end) begin
            n_col      = '0;
            n_row      = '0;
            n_row_base = r_origin;
        end else if (w_row_end) begin
            n_col      = '0;
            n_row      = w_row + COORD_BITS'(1);
            n_row_base = w_base + AW'(r_win_w);
        end else begin
            n_col      = w_col + COORD_BITS'(1);
            n_row      = w_row;
            n_row_base = w_base;
        end
    end

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade.mode  <= ckfb_pkg::FADE_STATIC;
            r_fade.level <= 8'd0;
            r_key_color  <= 32'd0;
            r_key_valid  <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_row_base   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fade      <= n_fade;
                r_key_color <= n_key_color;
                r_key_valid <= n_key_valid;
                r_col       <= n_col;
                r_row       <= n_row;
                r_row_base  <= n_row_base;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out;
        end
    end

endmodule

[dv/color_key_fade_blit_core_test.sv]
module color_key_fade_blit_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ckfb_pkg::*;

    // Quiet cycles allowed before the run is declared hung
    localparam int HANG_LIMIT = 1000;
    localparam int MAX_REPORTS = 10;
    // Index past the register list, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER[7] = '{
        REG_WINDOW_WIDTH, REG_WINDOW_HEIGHT, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
        REG_POS_X, REG_POS_Y, REG_FADE_TEMPO
    };
    localparam int REG_BITS[7] = '{13, 13, 13, 13, 12, 12, 8};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;

    color_key_fade_blit_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #1ns i_clk = 1'b1;
        #1ns i_clk = 1'b0;
    end

    // Shadow of the block: registers at their reset values, then blit state
    logic [12:0]          win_w = 13'd1024;
    logic [12:0]          win_h = 13'd768;
    logic [12:0]          img_w = 13'd1;
    logic [12:0]          img_h = 13'd1;
    logic [11:0]          pos_x = '0;
    logic [11:0]          pos_y = '0;
    logic [7:0]           fade_tempo = 8'd1;
    logic [7:0]           fade_level = '0;
    t_fade_mode           fade_mode = FADE_STATIC;
    logic [31:0]          key_color = '0;
    logic                 key_valid = 1'b0;
    logic [11:0]          col_cnt = '0;
    logic [11:0]          row_cnt = '0;
    logic [ADDR_BITS-1:0] row_base = '0;

    t_out_item   pending_blits[$];
    int          blit_errors = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;
    int unsigned reg_plan[7];

    typedef struct packed {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_directed_row;

    t_directed_row directed_rows[$];

    function automatic logic [ADDR_BITS-1:0] layer_origin();
        int unsigned o;
        o = 32'(win_w) * 32'(pos_y) + 32'(pos_x);
        return o[ADDR_BITS-1:0];
    endfunction

    // Expected layer write for one pixel; advances the shadow state
    function automatic t_out_item predict_blit(t_in_item it);
        t_out_item r;
        bit        hit, row_end, img_end;
        if (it.begin_image) begin
            col_cnt = '0;
            row_cnt = '0;
            row_base = layer_origin();
            case (it.action)
                ACT_KEEP: ;
                ACT_FADE_IN: fade_mode = FADE_IN;
                ACT_FADE_AWAY: fade_mode = FADE_AWAY;
                ACT_STOP: fade_mode = FADE_STATIC;
                default: ;
            endcase
            // one fade step per pass; a fade in at zero keeps its mode
            if (fade_mode == FADE_IN && fade_level != 0) begin
                if (fade_tempo >= fade_level) begin
                    fade_level = '0;
                    fade_mode = FADE_STATIC;
                end else begin
                    fade_level = fade_level - fade_tempo;
                end
            end
            if (fade_mode == FADE_AWAY && fade_level != FADE_MAX) begin
                if (int'(fade_level) + int'(fade_tempo) >= int'(FADE_MAX)) begin
                    fade_level = FADE_MAX;
                    fade_mode = FADE_STATIC;
                end else begin
                    fade_level = fade_level + fade_tempo;
                end
            end
            if (it.key_capture) begin
                key_color = it.pixel_in;
                key_valid = 1'b1;
            end
        end

        hit = (it.pixel_in == KEY_MARKER) || (key_valid && it.pixel_in == key_color);
        row_end = (int'(col_cnt) + 1 >= int'(img_w));
        img_end = row_end && (int'(row_cnt) + 1 >= int'(img_h));
        r.layer_address = row_base + ADDR_BITS'(col_cnt);
        r.pixel_out = hit ? KEY_MARKER : {fade_level, it.pixel_in[23:0]};
        r.in_window = (int'(pos_x) + int'(col_cnt) < int'(win_w)) &&
                      (int'(pos_y) + int'(row_cnt) < int'(win_h));
        r.keyed = hit;
        r.end_of_image = img_end;

        // counters move to the next column, row or back to the origin
        if (img_end) begin
            col_cnt = '0;
            row_cnt = '0;
            row_base = layer_origin();
        end else if (row_end) begin
            col_cnt = '0;
            row_cnt = row_cnt + 12'd1;
            row_base = row_base + ADDR_BITS'(win_w);
        end else begin
            col_cnt = col_cnt + 12'd1;
        end
        return r;
    endfunction

    function automatic void add_row(logic [31:0] px, bit first, bit cap, logic [1:0] act,
                                     bit typed, logic [31:0] px_out, bit hit);
        t_directed_row row;
        row.stim = '{pixel_in: px, begin_image: first, key_capture: cap, action: act};
        row.typed = typed;
        // reset setup: 1x1 image at the layer origin, always inside
        row.want = '{layer_address: '0, pixel_out: px_out, in_window: 1'b1,
                     keyed: hit, end_of_image: 1'b1};
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Mostly random pixels, with key hits, markers and extremes mixed in
    function automatic logic [31:0] source_pixel();
        case ($urandom_range(19))
            0, 1: return key_color;
            2: return KEY_MARKER;
            3: return 32'h0000_0000;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_pixel(input t_in_item it, input bit typed, input t_out_item typed_out);
        bit        took;
        t_out_item want_here;
        i_in_valid <= 1'b1;
        i_in_data <= it;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_in_ready;
            if (took) begin
                want_here = predict_blit(it);
                if (typed)
                    want_here = typed_out;
                pending_blits.push_back(want_here);
            end
            @(posedge i_clk);
        end
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold input until every expected result is out, plus the pipeline latency
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_blits.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        bit took;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_cfg_ready;
            if (took) begin
                case (idx)
                    REG_WINDOW_WIDTH: win_w = data[12:0];
                    REG_WINDOW_HEIGHT: win_h = data[12:0];
                    REG_IMAGE_WIDTH: img_w = data[12:0];
                    REG_IMAGE_HEIGHT: img_h = data[12:0];
                    REG_POS_X: pos_x = data[11:0];
                    REG_POS_Y: pos_y = data[11:0];
                    REG_FADE_TEMPO: fade_tempo = data[7:0];
                    default: ;
                endcase
            end
            @(posedge i_clk);
        end
    endtask

    // Write the planned values, all or a random subset; junk above each register's width must be dropped
    task automatic program_regs(input bit every);
        int unsigned data;
        for (int i = 0; i < 7; i++) begin
            if (every || $urandom_range(9) < 6) begin
                data = reg_plan[i];
                if ($urandom_range(3) == 0)
                    data = data | ($urandom & ~((32'd1 << REG_BITS[i]) - 1));
                cfg_write(REG_ORDER[i], CFG_DATA_W'(data));
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Passes of image-sized runs with random content, plus stray first-pixel flags when noisy
    task automatic run_phase(input int items, input bit noisy);
        int       sent, span, hold_at;
        t_in_item it;
        sent = 0;
        hold_at = $urandom_range(items - 1, 1);
        while (sent < items) begin
            span = (img_w == 0 ? 1 : int'(img_w)) * (img_h == 0 ? 1 : int'(img_h));
            if (span > items - sent)
                span = items - sent;
            for (int k = 0; k < span; k++) begin
                it.pixel_in = source_pixel();
                it.begin_image = (k == 0) ? ($urandom_range(11) != 0)
                                          : (noisy && $urandom_range(24) == 0);
                it.key_capture = ($urandom_range(2) == 0);
                it.action = 2'($urandom_range(3));
                send_pixel(it, 1'b0, '0);
                sent++;
                if (sent == hold_at)
                    drain();
                else
                    pause_sender(pick_gap());
            end
        end
    endtask

    // Result sink: random stalls, mostly short, sometimes long
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (calm || $urandom_range(9) < 7) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b0;
            stall_left <= ($urandom_range(7) == 0) ? $urandom_range(24, 8) : $urandom_range(2);
        end
    end

    // Check each output transaction and watch for a hang
    t_out_item want;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_blits.size() == 0) begin
                    blit_errors++;
                    if (blit_errors <= MAX_REPORTS)
                        $display("unexpected result: addr %h pixel %h",
                                 o_out_data.layer_address, o_out_data.pixel_out);
                end else begin
                    want = pending_blits.pop_front();
                    if (o_out_data.layer_address !== want.layer_address ||
                        o_out_data.pixel_out !== want.pixel_out ||
                        o_out_data.in_window !== want.in_window ||
                        o_out_data.keyed !== want.keyed ||
                        o_out_data.end_of_image !== want.end_of_image) begin
                        blit_errors++;
                        if (blit_errors <= MAX_REPORTS)
                            $display({"mismatch exp/got: addr %h/%h pixel %h/%h ",
                                      "win %b/%b keyed %b/%b end %b/%b"},
                                     want.layer_address, o_out_data.layer_address,
                                     want.pixel_out, o_out_data.pixel_out,
                                     want.in_window, o_out_data.in_window,
                                     want.keyed, o_out_data.keyed,
                                     want.end_of_image, o_out_data.end_of_image);
                    end
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= HANG_LIMIT) begin
                $display("[color_key_fade_blit_core] ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setup: 1x1 image, window 1024 wide, tempo 1, no key, fade level 0
        add_row(32'h1234_5678, 0, 0, ACT_KEEP, 1, 32'h0034_5678, 0);
        add_row(KEY_MARKER, 0, 0, ACT_KEEP, 1, KEY_MARKER, 1);
        add_row(32'hFFFF_FFFF, 1, 0, ACT_FADE_AWAY, 1, 32'h01FF_FFFF, 0);
        add_row(32'h0000_0000, 1, 0, ACT_KEEP, 1, 32'h0200_0000, 0);
        // capture a key on the first pixel, then hit it on a later pass
        add_row(32'hA5A5_A5A5, 1, 1, ACT_STOP, 1, KEY_MARKER, 1);
        add_row(32'hA5A5_A5A5, 0, 0, ACT_KEEP, 1, KEY_MARKER, 1);
        // capture and action are ignored off the first pixel
        add_row(32'h5A5A_5A5A, 0, 1, ACT_FADE_AWAY, 1, 32'h025A_5A5A, 0);
        add_row(32'h0000_0001, 1, 0, ACT_FADE_IN, 1, 32'h0100_0001, 0);
        add_row(32'h00FF_FFFF, 1, 0, ACT_KEEP, 1, 32'h00FF_FFFF, 0);
        // fade in from zero stays in fade in
        add_row(32'h8000_0000, 1, 0, ACT_FADE_IN, 1, 32'h0000_0000, 0);
        add_row(32'h7FFF_FFFF, 1, 0, ACT_KEEP, 1, 32'h00FF_FFFF, 0);
        // a new capture replaces the old key
        add_row(32'hFF66_6998, 1, 1, ACT_FADE_AWAY, 1, KEY_MARKER, 1);
        add_row(32'hA5A5_A5A5, 0, 0, ACT_KEEP, 1, 32'h01A5_A5A5, 0);
        add_row(KEY_MARKER, 1, 1, ACT_STOP, 1, KEY_MARKER, 1);
        add_row(32'h5555_5555, 1, 0, ACT_FADE_AWAY, 0, '0, 0);
        add_row(32'hAAAA_AAAA, 0, 0, ACT_KEEP, 0, '0, 0);
        foreach (directed_rows[i]) begin
            send_pixel(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
            pause_sender(pick_gap());
        end

        for (int p = 0; p < 13; p++) begin
            drain();
            case (p)
                0: begin
                    // 4096x4096 layer, origin at the far corner: addresses wrap
                    reg_plan = '{4096, 4096, 3, 2, 4095, 4095, 255};
                    program_regs(1'b1);
                end
                1: begin
                    // zero sizes act as one, zero tempo, empty window
                    cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
                    reg_plan = '{0, 0, 0, 0, 0, 0, 0};
                    program_regs(1'b1);
                end
                2: begin
                    // all ones: widths masked, oversize image and window
                    reg_plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF};
                    program_regs(1'b1);
                end
                default: begin
                    reg_plan[0] = ($urandom_range(6) == 0) ? $urandom_range(8191)
                                                           : $urandom_range(64, 1);
                    reg_plan[1] = ($urandom_range(6) == 0) ? $urandom_range(8191)
                                                           : $urandom_range(48, 1);
                    case ($urandom_range(19))
                        0: reg_plan[2] = 0;
                        1, 2, 3: reg_plan[2] = $urandom_range(40, 7);
                        default: reg_plan[2] = $urandom_range(6, 1);
                    endcase
                    reg_plan[3] = ($urandom_range(5) == 0) ? $urandom_range(12)
                                                           : $urandom_range(5, 1);
                    reg_plan[4] = ($urandom_range(6) == 0) ? $urandom_range(4095)
                                                           : $urandom_range(reg_plan[0] + 3);
                    reg_plan[5] = ($urandom_range(6) == 0) ? $urandom_range(4095)
                                                           : $urandom_range(reg_plan[1] + 3);
                    case ($urandom_range(6))
                        0: reg_plan[6] = 0;
                        1: reg_plan[6] = 255;
                        2, 3: reg_plan[6] = $urandom_range(10, 1);
                        default: reg_plan[6] = $urandom_range(255);
                    endcase
                    program_regs(1'b0);
                end
            endcase
            calm = (p == 2) || (p % 4 == 3);
            if (p == 2)
                run_phase(30, 1'b0);
            else
                run_phase(30, 1'b1);
        end

        drain();
        calm = 1'b0;
        repeat (4) @(posedge i_clk);
        if (blit_errors == 0)
            $display("[color_key_fade_blit_core] OK");
        else
            $display("[color_key_fade_blit_core] ERROR");
        $finish;
    end

endmodule
